>>> design/tksd_pkg.sv
package tksd_pkg;

  // Position within a key prefix
  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_ESC   = 4'd1,
    ST_CSI   = 4'd2,
    ST_1     = 4'd3,
    ST_1SEMI = 4'd4,
    ST_15    = 4'd5,
    ST_3     = 4'd6,
    ST_3SEMI = 4'd7,
    ST_35    = 4'd8,
    ST_4     = 4'd9,
    ST_EXT   = 4'd10
  } seq_state_t;

  typedef enum logic [3:0] {
    EV_NORMAL      = 4'd0,
    EV_ENTER       = 4'd1,
    EV_BACKSPACE   = 4'd2,
    EV_ALT_BS      = 4'd3,
    EV_UP          = 4'd4,
    EV_DOWN        = 4'd5,
    EV_LEFT        = 4'd6,
    EV_RIGHT       = 4'd7,
    EV_HOME        = 4'd8,
    EV_END         = 4'd9,
    EV_DELETE      = 4'd10,
    EV_CTRL_LEFT   = 4'd11,
    EV_CTRL_RIGHT  = 4'd12,
    EV_CTRL_DELETE = 4'd13
  } event_kind_t;

  localparam logic MODE_ANSI    = 1'b0;
  localparam logic MODE_CONSOLE = 1'b1;

  // Byte codes
  localparam logic [7:0] KEY_LF      = 8'd10;
  localparam logic [7:0] KEY_CR      = 8'd13;
  localparam logic [7:0] KEY_BS      = 8'd8;
  localparam logic [7:0] KEY_DEL     = 8'd127;
  localparam logic [7:0] KEY_ESC     = 8'd27;
  localparam logic [7:0] KEY_EXT     = 8'd224;
  localparam logic [7:0] KEY_LBRACK  = 8'h5B;
  localparam logic [7:0] KEY_TILDE   = 8'h7E;
  localparam logic [7:0] KEY_SEMI    = 8'h3B;
  localparam logic [7:0] KEY_DIGIT_1 = 8'h31;
  localparam logic [7:0] KEY_DIGIT_3 = 8'h33;
  localparam logic [7:0] KEY_DIGIT_4 = 8'h34;
  localparam logic [7:0] KEY_DIGIT_5 = 8'h35;
  localparam logic [7:0] KEY_A       = 8'h41;
  localparam logic [7:0] KEY_B       = 8'h42;
  localparam logic [7:0] KEY_C       = 8'h43;
  localparam logic [7:0] KEY_D       = 8'h44;
  localparam logic [7:0] KEY_F       = 8'h46;
  localparam logic [7:0] KEY_H       = 8'h48;
  localparam logic [7:0] KEY_EOI     = 8'd255;

  // Console scan codes after the extended prefix
  localparam logic [7:0] SCAN_UP     = 8'd72;
  localparam logic [7:0] SCAN_DOWN   = 8'd80;
  localparam logic [7:0] SCAN_LEFT   = 8'd75;
  localparam logic [7:0] SCAN_RIGHT  = 8'd77;
  localparam logic [7:0] SCAN_HOME   = 8'd71;
  localparam logic [7:0] SCAN_END    = 8'd79;
  localparam logic [7:0] SCAN_DELETE = 8'd83;

  typedef struct packed {
    logic        emit;
    event_kind_t kind;
    logic [7:0]  ch;
  } dec_res_t;

endpackage

>>> design/tksd_decode.sv
module tksd_decode (
  input  tksd_pkg::seq_state_t state,
  input  logic                 mode,
  input  logic [7:0]           key_byte,
  input  logic                 eoi,
  output tksd_pkg::seq_state_t state_nxt,
  output tksd_pkg::dec_res_t   res
);

  tksd_pkg::event_kind_t kind;
  logic                  emit;

  // Next state: only prefix bytes move away from idle
  always_comb begin
    state_nxt = tksd_pkg::ST_IDLE;
    if (!eoi) begin
      unique case (state)
        tksd_pkg::ST_IDLE: begin
          if (mode == tksd_pkg::MODE_ANSI && key_byte == tksd_pkg::KEY_ESC)
            state_nxt = tksd_pkg::ST_ESC;
          else if (mode == tksd_pkg::MODE_CONSOLE && key_byte == tksd_pkg::KEY_EXT)
            state_nxt = tksd_pkg::ST_EXT;
        end
        tksd_pkg::ST_ESC: begin
          if (key_byte == tksd_pkg::KEY_LBRACK) state_nxt = tksd_pkg::ST_CSI;
        end
        tksd_pkg::ST_CSI: begin
          if (key_byte == tksd_pkg::KEY_DIGIT_1)      state_nxt = tksd_pkg::ST_1;
          else if (key_byte == tksd_pkg::KEY_DIGIT_3) state_nxt = tksd_pkg::ST_3;
          else if (key_byte == tksd_pkg::KEY_DIGIT_4) state_nxt = tksd_pkg::ST_4;
        end
        tksd_pkg::ST_1: begin
          if (key_byte == tksd_pkg::KEY_SEMI) state_nxt = tksd_pkg::ST_1SEMI;
        end
        tksd_pkg::ST_1SEMI: begin
          if (key_byte == tksd_pkg::KEY_DIGIT_5) state_nxt = tksd_pkg::ST_15;
        end
        tksd_pkg::ST_3: begin
          if (key_byte == tksd_pkg::KEY_SEMI) state_nxt = tksd_pkg::ST_3SEMI;
        end
        tksd_pkg::ST_3SEMI: begin
          if (key_byte == tksd_pkg::KEY_DIGIT_5) state_nxt = tksd_pkg::ST_35;
        end
        default: state_nxt = tksd_pkg::ST_IDLE;
      endcase
    end
  end

  // Event: anything that does not extend a prefix ends it
  always_comb begin
    emit = 1'b1;
    kind = tksd_pkg::EV_NORMAL;
    if (eoi) begin
      kind = (state == tksd_pkg::ST_IDLE) ? tksd_pkg::EV_ENTER : tksd_pkg::EV_NORMAL;
    end else begin
      unique case (state)
        tksd_pkg::ST_IDLE: begin
          priority if (key_byte == tksd_pkg::KEY_CR || key_byte == tksd_pkg::KEY_LF)
            kind = tksd_pkg::EV_ENTER;
          else if (key_byte == tksd_pkg::KEY_BS || key_byte == tksd_pkg::KEY_DEL)
            kind = tksd_pkg::EV_BACKSPACE;
          else if (mode == tksd_pkg::MODE_ANSI && key_byte == tksd_pkg::KEY_ESC)
            emit = 1'b0;
          else if (mode == tksd_pkg::MODE_CONSOLE && key_byte == tksd_pkg::KEY_EXT)
            emit = 1'b0;
          else
            kind = tksd_pkg::EV_NORMAL;
        end
        tksd_pkg::ST_ESC: begin
          if (key_byte == tksd_pkg::KEY_BS || key_byte == tksd_pkg::KEY_DEL)
            kind = tksd_pkg::EV_ALT_BS;
          else if (key_byte == tksd_pkg::KEY_LBRACK)
            emit = 1'b0;
        end
        tksd_pkg::ST_CSI: begin
          unique case (key_byte)
            tksd_pkg::KEY_A:       kind = tksd_pkg::EV_UP;
            tksd_pkg::KEY_B:       kind = tksd_pkg::EV_DOWN;
            tksd_pkg::KEY_C:       kind = tksd_pkg::EV_RIGHT;
            tksd_pkg::KEY_D:       kind = tksd_pkg::EV_LEFT;
            tksd_pkg::KEY_H:       kind = tksd_pkg::EV_HOME;
            tksd_pkg::KEY_F:       kind = tksd_pkg::EV_END;
            tksd_pkg::KEY_DIGIT_1,
            tksd_pkg::KEY_DIGIT_3,
            tksd_pkg::KEY_DIGIT_4: emit = 1'b0;
            default:               kind = tksd_pkg::EV_NORMAL;
          endcase
        end
        tksd_pkg::ST_1: begin
          if (key_byte == tksd_pkg::KEY_TILDE)     kind = tksd_pkg::EV_HOME;
          else if (key_byte == tksd_pkg::KEY_SEMI) emit = 1'b0;
        end
        tksd_pkg::ST_1SEMI: begin
          if (key_byte == tksd_pkg::KEY_DIGIT_5) emit = 1'b0;
        end
        tksd_pkg::ST_15: begin
          if (key_byte == tksd_pkg::KEY_D)      kind = tksd_pkg::EV_CTRL_LEFT;
          else if (key_byte == tksd_pkg::KEY_C) kind = tksd_pkg::EV_CTRL_RIGHT;
        end
        tksd_pkg::ST_3: begin
          if (key_byte == tksd_pkg::KEY_TILDE)     kind = tksd_pkg::EV_DELETE;
          else if (key_byte == tksd_pkg::KEY_SEMI) emit = 1'b0;
        end
        tksd_pkg::ST_3SEMI: begin
          if (key_byte == tksd_pkg::KEY_DIGIT_5) emit = 1'b0;
        end
        tksd_pkg::ST_35: begin
          if (key_byte == tksd_pkg::KEY_TILDE) kind = tksd_pkg::EV_CTRL_DELETE;
        end
        tksd_pkg::ST_4: begin
          if (key_byte == tksd_pkg::KEY_TILDE) kind = tksd_pkg::EV_END;
        end
        tksd_pkg::ST_EXT: begin
          unique case (key_byte)
            tksd_pkg::SCAN_UP:     kind = tksd_pkg::EV_UP;
            tksd_pkg::SCAN_DOWN:   kind = tksd_pkg::EV_DOWN;
            tksd_pkg::SCAN_LEFT:   kind = tksd_pkg::EV_LEFT;
            tksd_pkg::SCAN_RIGHT:  kind = tksd_pkg::EV_RIGHT;
            tksd_pkg::SCAN_HOME:   kind = tksd_pkg::EV_HOME;
            tksd_pkg::SCAN_END:    kind = tksd_pkg::EV_END;
            tksd_pkg::SCAN_DELETE: kind = tksd_pkg::EV_DELETE;
            default:               kind = tksd_pkg::EV_NORMAL;
          endcase
        end
        default: kind = tksd_pkg::EV_NORMAL;
      endcase
    end
  end

  always_comb begin
    res.emit = emit;
    res.kind = kind;
    if (kind != tksd_pkg::EV_NORMAL) res.ch = 8'd0;
    else if (eoi)                    res.ch = tksd_pkg::KEY_EOI;
    else                             res.ch = key_byte;
  end

endmodule

>>> design/terminal_key_sequence_decoder_unit.sv
// Keyboard key decoder. Each input request carries one raw byte (or an end-of-input
// flag in in_tuser) and yields at most one key event on the output: bytes that only
// extend an escape or extended prefix produce nothing. cfg_we/cfg_wdata select the
// mode (0 ANSI escape sequences, 1 console 224-prefixed scan codes); a write also
// drops any partial prefix and must only happen while the block is idle. A byte
// that breaks a sequence comes out as a normal event carrying that byte. Rate: one
// request per cycle, sustained while the output is not stalled; a byte is held in
// an input register, decoded against the prefix state there, and its event lands
// in the output register, which drives out_tvalid. The single prefix-state
// register, updated once per byte, is what bounds the rate.
module terminal_key_sequence_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,    // decode_mode
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,     // [7:0] key_byte
  input  logic       in_tuser,     // [0] end_of_input
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,    // [7:0] character
  output logic [3:0] out_tuser     // [3:0] event_kind
);

  // Input register
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       in_eoi_r;

  // Prefix state and mode
  tksd_pkg::seq_state_t state_r, state_nxt, dec_state_nxt;
  logic                 mode_r;

  // Result register
  logic                  out_valid_r, out_valid_nxt;
  tksd_pkg::event_kind_t out_kind_r;
  logic [7:0]            out_char_r;

  tksd_pkg::dec_res_t dec_res;
  logic               out_free;
  logic               advance;
  logic               load_out;

  tksd_decode u_decode (
    .state     (state_r),
    .mode      (mode_r),
    .key_byte  (in_byte_r),
    .eoi       (in_eoi_r),
    .state_nxt (dec_state_nxt),
    .res       (dec_res)
  );

  // Result slot is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_tready;
  // Advance the held byte unless its event would overrun a stalled result
  assign advance  = in_valid_r && (!dec_res.emit || out_free);
  assign load_out = advance && dec_res.emit;
  assign in_tready = !in_valid_r || advance;

  assign in_valid_nxt  = (in_tvalid && in_tready) || (in_valid_r && !advance);
  assign out_valid_nxt = load_out || (out_valid_r && !out_tready);

  always_comb begin
    state_nxt = state_r;
    if (cfg_we)       state_nxt = tksd_pkg::ST_IDLE;   // drop partial prefix
    else if (advance) state_nxt = dec_state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= tksd_pkg::ST_IDLE;
      mode_r      <= tksd_pkg::MODE_ANSI;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
      if (cfg_we) mode_r <= cfg_wdata;
    end
  end

  // Payload: capture on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eoi_r  <= in_tuser;
    end
    if (load_out) begin
      out_kind_r <= dec_res.kind;
      out_char_r <= dec_res.ch;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tuser  = out_kind_r;

`ifndef SYNTHESIS
  // Only normal events carry a character
  a_char_only_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != tksd_pkg::EV_NORMAL |-> out_char_r == 8'd0)
    else $error("non-normal event carries a character");

  // Console mode never walks the escape-sequence states
  a_console_states: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == tksd_pkg::MODE_CONSOLE |->
      state_r == tksd_pkg::ST_IDLE || state_r == tksd_pkg::ST_EXT)
    else $error("console mode in an escape state");

  // ANSI mode never sits on the extended prefix
  a_ansi_no_ext: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == tksd_pkg::MODE_ANSI |-> state_r != tksd_pkg::ST_EXT)
    else $error("ANSI mode in extended prefix state");

  // A mode write leaves the decoder idle
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> state_r == tksd_pkg::ST_IDLE)
    else $error("prefix survived a mode write");

  // A held byte with a pending event never overwrites a stalled result
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !load_out)
    else $error("result overwritten while stalled");
`endif

endmodule
